@@ src/lz77_byte_depacker_top_macros.svh @@
// Assertion macros for the byte depacker.
`ifndef LZ77_BYTE_DEPACKER_TOP_MACROS_SVH
`define LZ77_BYTE_DEPACKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lz77 byte depacker: implication check failed");
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lz77 byte depacker: next-cycle check failed");
`else
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/lzd_pkg.sv @@
package lzd_pkg;

  localparam int HIST_DEPTH   = 256;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int LANES        = 4;
  localparam int LANE_AW      = $clog2(LANES);
  localparam int CNT_W        = 3;
  localparam int MAX_LIT_CTRL = 127;
  localparam int MIN_MATCH    = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef logic [1:0] cmd_kind_t;

  localparam cmd_kind_t CMD_LIT  = 2'd0;
  localparam cmd_kind_t CMD_COPY = 2'd1;
  localparam cmd_kind_t CMD_END  = 2'd2;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic [7:0]         len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

@@ src/lzd_ram.sv @@
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/lzd_fifo.sv @@
module lzd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  lzd_pkg::push_t push,
  input  logic           pop,
  output lzd_pkg::cmd_t  dout,
  output logic           full,
  output logic           empty
);

  import lzd_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic [FIFO_AW:0]   cnt_nxt;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

@@ src/lzd_front.sv @@
module lzd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_packed_byte,
  output logic           in_stall,
  input  logic           fifo_full,
  input  logic           back_busy,
  output lzd_pkg::push_t push
);

  import lzd_pkg::*;

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_OFS  = 2'd2;

  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic [6:0] lit_left_r;
  logic [6:0] lit_left_nxt;
  logic [7:0] mlen_r;
  logic [7:0] mlen_nxt;
  logic       accept;

  assign in_stall = fifo_full || back_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_nxt     = phase_r;
    lit_left_nxt  = lit_left_r;
    mlen_nxt      = mlen_r;
    push.valid    = 1'b0;
    push.cmd.kind = CMD_LIT;
    push.cmd.data = in_packed_byte;
    push.cmd.len  = mlen_r;
    if (accept) begin
      unique case (phase_r)
        PH_LIT: begin
          push.valid   = 1'b1;
          push.cmd.kind = CMD_LIT;
          lit_left_nxt = lit_left_r - 7'd1;
          if (lit_left_r == 7'd1) begin
            phase_nxt = PH_CTRL;
          end
        end
        PH_OFS: begin
          push.valid    = 1'b1;
          push.cmd.kind = CMD_COPY;
          phase_nxt     = PH_CTRL;
        end
        default: begin
          // control byte; the unused phase code lands here too
          phase_nxt = PH_CTRL;
          if (in_packed_byte == 8'd0) begin
            push.valid    = 1'b1;
            push.cmd.kind = CMD_END;
          end else if (in_packed_byte <= 8'(MAX_LIT_CTRL)) begin
            lit_left_nxt = in_packed_byte[6:0];
            phase_nxt    = PH_LIT;
          end else begin
            mlen_nxt  = in_packed_byte - 8'(MAX_LIT_CTRL + 1 - MIN_MATCH);
            phase_nxt = PH_OFS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CTRL;
      lit_left_r <= '0;
      mlen_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      mlen_r     <= mlen_nxt;
    end
  end

endmodule

@@ src/lzd_back.sv @@
module lzd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fifo_empty,
  input  lzd_pkg::cmd_t             cmd,
  output logic                      pop,
  output logic                      clr_busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte_0,
  output logic [7:0]                out_byte_1,
  output logic [7:0]                out_byte_2,
  output logic [7:0]                out_byte_3,
  output logic [lzd_pkg::CNT_W-1:0] out_byte_count,
  output logic                      out_last_of_run,
  output logic                      out_end_of_stream
);

  import lzd_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_COPY  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [HIST_AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [7:0]         iss_left_r, iss_left_nxt;
  logic [7:0]         arr_left_r, arr_left_nxt;
  logic               pend_r, pend_nxt;
  logic               byp_r, byp_nxt;
  logic [7:0]         byp_data_r, byp_data_nxt;
  logic [7:0]         lane_r [LANES];
  logic [7:0]         lane_nxt [LANES];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         ob_r [LANES];
  logic [7:0]         ob_nxt [LANES];
  logic [CNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic               olast_r, olast_nxt;
  logic               oeos_r, oeos_nxt;

  logic               we;
  logic [7:0]         wdata;
  logic [7:0]         ram_rdata;
  logic [7:0]         arr_byte;
  logic               out_free;
  logic               flush;
  logic               issue;
  logic [CNT_W-1:0]   eff_cnt;

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign arr_byte = byp_r ? byp_data_r : ram_rdata;
  assign flush    = (state_r == ST_COPY) && out_free &&
                    ((cnt_r == CNT_W'(LANES)) || ((arr_left_r == '0) && (cnt_r != '0)));
  assign eff_cnt  = flush ? '0 : cnt_r;
  // issue a read only if its byte will find a free lane when it returns
  assign issue    = (state_r == ST_COPY) && (iss_left_r != '0) &&
                    (((CNT_W+1)'(eff_cnt) + (CNT_W+1)'(pend_r)) < (CNT_W+1)'(LANES));
  assign pop      = (state_r == ST_IDLE) && !fifo_empty && out_free;
  assign clr_busy = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rd_addr_nxt  = rd_addr_r;
    iss_left_nxt = iss_left_r;
    arr_left_nxt = arr_left_r;
    pend_nxt     = 1'b0;
    // forward the byte being written when the read hits the same slot
    byp_nxt      = pend_r && (rd_addr_r == wp_r);
    byp_data_nxt = arr_byte;
    lane_nxt     = lane_r;
    cnt_nxt      = cnt_r;
    ob_nxt       = ob_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = olast_r;
    oeos_nxt     = oeos_r;
    out_valid_nxt = out_valid_r && out_stall;
    we           = 1'b0;
    wdata        = arr_byte;

    unique case (state_r)
      ST_CLEAR: begin
        we     = 1'b1;
        wdata  = '0;
        wp_nxt = wp_r + 1'b1;
        if (wp_r == HIST_AW'(HIST_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd.kind)
            CMD_LIT: begin
              we            = 1'b1;
              wdata         = cmd.data;
              wp_nxt        = wp_r + 1'b1;
              for (int i = 0; i < LANES; i++) ob_nxt[i] = '0;
              ob_nxt[0]     = cmd.data;
              ocnt_nxt      = CNT_W'(1);
              olast_nxt     = 1'b1;
              oeos_nxt      = 1'b0;
              out_valid_nxt = 1'b1;
            end
            CMD_END: begin
              for (int i = 0; i < LANES; i++) ob_nxt[i] = '0;
              ocnt_nxt      = '0;
              olast_nxt     = 1'b1;
              oeos_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
            end
            CMD_COPY: begin
              state_nxt    = ST_COPY;
              iss_left_nxt = cmd.len;
              arr_left_nxt = cmd.len;
              // start at wp - (data + 1)
              rd_addr_nxt  = wp_r + ~cmd.data;
              cnt_nxt      = '0;
              for (int i = 0; i < LANES; i++) lane_nxt[i] = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_COPY: begin
        if (issue) begin
          rd_addr_nxt  = rd_addr_r + 1'b1;
          iss_left_nxt = iss_left_r - 8'd1;
        end
        pend_nxt = issue;
        if (flush) begin
          ob_nxt        = lane_r;
          ocnt_nxt      = cnt_r;
          olast_nxt     = (arr_left_r == '0);
          oeos_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          for (int i = 0; i < LANES; i++) lane_nxt[i] = '0;
          if (arr_left_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
        if (pend_r) begin
          we                             = 1'b1;
          wdata                          = arr_byte;
          wp_nxt                         = wp_r + 1'b1;
          lane_nxt[eff_cnt[LANE_AW-1:0]] = arr_byte;
          cnt_nxt                        = eff_cnt + 1'b1;
          arr_left_nxt                   = arr_left_r - 8'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wp_r        <= '0;
      iss_left_r  <= '0;
      arr_left_r  <= '0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      iss_left_r  <= iss_left_nxt;
      arr_left_r  <= arr_left_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    byp_r      <= byp_nxt;
    byp_data_r <= byp_data_nxt;
    lane_r     <= lane_nxt;
    ob_r       <= ob_nxt;
    ocnt_r     <= ocnt_nxt;
    olast_r    <= olast_nxt;
    oeos_r     <= oeos_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte_0        = ob_r[0];
  assign out_byte_1        = ob_r[1];
  assign out_byte_2        = ob_r[2];
  assign out_byte_3        = ob_r[3];
  assign out_byte_count    = ocnt_r;
  assign out_last_of_run   = olast_r;
  assign out_end_of_stream = oeos_r;

endmodule

@@ src/lz77_byte_depacker_top.sv @@
// A literal or end-of-stream request passes through the command FIFO and is popped into the
// registered output; a match starts its history reads once its offset request is popped.
// Input bytes are taken one per cycle while in_stall is low; a match reads history one byte
// per cycle while the output is not stalled and skips one read at each full result.
// Reset (rst_n low, synchronous) clears control state, then a pass zeroes all 256 slots of the
// history RAM one slot per cycle with in_stall held high.
`include "lz77_byte_depacker_top_macros.svh"

module lz77_byte_depacker_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_packed_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte_0,
  output logic [7:0]                out_byte_1,
  output logic [7:0]                out_byte_2,
  output logic [7:0]                out_byte_3,
  output logic [lzd_pkg::CNT_W-1:0] out_byte_count,
  output logic                      out_last_of_run,
  output logic                      out_end_of_stream
);

  import lzd_pkg::*;

  push_t push;
  cmd_t  cmd;
  logic  pop;
  logic  fifo_full;
  logic  fifo_empty;
  logic  clr_busy;
  logic  res_empty;

  lzd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_packed_byte (in_packed_byte),
    .in_stall       (in_stall),
    .fifo_full      (fifo_full),
    .back_busy      (clr_busy),
    .push           (push)
  );

  lzd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .dout  (cmd),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  lzd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_empty        (fifo_empty),
    .cmd               (cmd),
    .pop               (pop),
    .clr_busy          (clr_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_0        (out_byte_0),
    .out_byte_1        (out_byte_1),
    .out_byte_2        (out_byte_2),
    .out_byte_3        (out_byte_3),
    .out_byte_count    (out_byte_count),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  assign res_empty = out_valid && (out_byte_count == '0);

  `LZD_ASSERT_IMPL(a_push_not_full, clk, rst_n, push.valid, !fifo_full)
  `LZD_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, pop, !fifo_empty)
  `LZD_ASSERT_NEXT(a_push_fills, clk, rst_n, push.valid && fifo_empty, !fifo_empty)
  `LZD_ASSERT_IMPL(a_empty_is_end, clk, rst_n, res_empty, out_end_of_stream && out_last_of_run)
  `LZD_ASSERT_IMPL(a_clear_blocks_input, clk, rst_n, clr_busy, in_stall)

endmodule
